### rtl/arp_cache_table_core_defines.svh
// Assertion macros shared by the ARP cache table RTL.
`ifndef ARP_CACHE_TABLE_CORE_DEFINES_SVH
`define ARP_CACHE_TABLE_CORE_DEFINES_SVH

`ifndef SYNTH
// Checks that a condition holds at every clock edge outside reset.
`define ARPC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Checks that a condition at one edge is followed by another at the next edge.
`define ARPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ARPC_ASSERT(lbl, cond, msg)
`define ARPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/arpc_pkg.sv
// Types and constants of the ARP cache table.
`default_nettype none
package arpc_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_DEL_IP  = 2'd1;
  localparam logic [1:0] MODE_DEL_ALL = 2'd2;
  localparam logic [1:0] MODE_FIND    = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic        dynamic_flag;
    logic [31:0] stamp;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] found_mac;
    logic        found_dynamic;
    logic [31:0] found_stamp;
    logic [4:0]  entry_index;
    logic [5:0]  entry_count;
    logic [5:0]  removed_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
    logic        kind;
  } entry_t;

endpackage
`default_nettype wire

### rtl/arp_cache_table_core.sv
// Top level of the ARP cache table: sequencer around one entry RAM.
`default_nettype none
`include "arp_cache_table_core_defines.svh"
// The table keeps up to ENTRIES entries packed from index 0 in insertion order,
// all four fields of an entry in one word of a single RAM with a registered
// read. One item is processed at a time. An add goes from acceptance straight
// to the done state, where its result is registered once the output register
// is free. Delete, delete-all and find walk every valid entry through the RAM
// read port, one entry a cycle; the deletes compact in place through the write
// port behind the read pointer. Their result is registered in the done state
// after the scan ends, and the block then returns to idle, where it accepts
// the next item. A new item is accepted once the previous result has moved
// into the output register, so a result may wait there while the next item
// runs; a result that cannot enter the output register holds the block in
// its done state. No clearing pass is needed after reset: only entries below
// the fill count are ever read.
module arp_cache_table_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire arpc_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output arpc_pkg::rsp_t     rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam int IDX_W = arpc_pkg::IDX_W;
  localparam int CNT_W = arpc_pkg::CNT_W;

  logic [1:0]            state;
  arpc_pkg::req_t        op;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic [CNT_W-1:0]      rd_idx;
  logic                  p_vld;
  logic [IDX_W-1:0]      p_idx;
  logic [CNT_W-1:0]      w;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  arpc_pkg::entry_t      hit_ent;
  arpc_pkg::rsp_t        rsp_next;

  logic                  issue;
  logic                  first_hit;
  logic                  drop;
  logic                  keep_wr;
  logic                  full;
  logic                  rsp_free;
  logic                  finish;
  logic                  add_wr;
  logic                  scan_end;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  arpc_pkg::entry_t      ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [$bits(arpc_pkg::entry_t)-1:0] ram_rdata;
  arpc_pkg::entry_t      q;
  arpc_pkg::entry_t      add_ent;

  assign req_ready = (state == S_IDLE);

  assign q        = arpc_pkg::entry_t'(ram_rdata);
  assign issue    = (state == S_SCAN) && (rd_idx < cnt);
  assign full     = (cnt == CNT_W'(arpc_pkg::ENTRIES));
  assign rsp_free = !rsp_valid || rsp_ready;
  assign finish   = (state == S_DONE) && rsp_free;
  assign add_wr   = finish && (op.mode == arpc_pkg::MODE_ADD) && !full;
  assign scan_end = (state == S_SCAN) && !issue && !p_vld;

  // Only the lowest-indexed IP match counts for delete and find.
  assign first_hit = p_vld && !hit && (q.ip == op.ip_addr) &&
                     ((op.mode == arpc_pkg::MODE_DEL_IP) || (op.mode == arpc_pkg::MODE_FIND));
  assign drop = p_vld &&
                (((op.mode == arpc_pkg::MODE_DEL_IP) && first_hit) ||
                 ((op.mode == arpc_pkg::MODE_DEL_ALL) && (q.kind == op.dynamic_flag)));
  // Kept entries are written back at the compacted position, which never
  // runs ahead of the entry just read.
  assign keep_wr = p_vld && (op.mode != arpc_pkg::MODE_FIND) && !drop;

  assign add_ent.ip    = op.ip_addr;
  assign add_ent.mac   = op.mac_addr;
  assign add_ent.stamp = op.stamp;
  assign add_ent.kind  = op.dynamic_flag;

  assign ram_we    = keep_wr || add_wr;
  assign ram_waddr = add_wr ? cnt[IDX_W-1:0] : w[IDX_W-1:0];
  assign ram_wdata = add_wr ? add_ent : q;
  assign ram_raddr = rd_idx[IDX_W-1:0];

  arpc_ram #(
    .WIDTH($bits(arpc_pkg::entry_t)),
    .DEPTH(arpc_pkg::ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (issue),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    rsp_next               = '0;
    rsp_next.status        = arpc_pkg::STATUS_OK;
    rsp_next.entry_count   = 6'(cnt);
    cnt_next               = cnt;
    case (op.mode)
      arpc_pkg::MODE_ADD: begin
        if (full) begin
          rsp_next.status = arpc_pkg::STATUS_FULL;
        end else begin
          cnt_next               = cnt + 1'b1;
          rsp_next.entry_index   = 5'(cnt);
          rsp_next.entry_count   = 6'(cnt_next);
        end
      end
      arpc_pkg::MODE_DEL_IP: begin
        if (hit) begin
          cnt_next               = w;
          rsp_next.entry_index   = 5'(hit_idx);
          rsp_next.entry_count   = 6'(w);
          rsp_next.removed_count = 6'(cnt - w);
        end else begin
          rsp_next.status = arpc_pkg::STATUS_MISS;
        end
      end
      arpc_pkg::MODE_DEL_ALL: begin
        cnt_next               = w;
        rsp_next.entry_count   = 6'(w);
        rsp_next.removed_count = 6'(cnt - w);
      end
      default: begin
        if (hit) begin
          rsp_next.found_mac     = hit_ent.mac;
          rsp_next.found_dynamic = hit_ent.kind;
          rsp_next.found_stamp   = hit_ent.stamp;
          rsp_next.entry_index   = 5'(hit_idx);
        end else begin
          rsp_next.status = arpc_pkg::STATUS_MISS;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
      p_vld     <= 1'b0;
    end else begin
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op     <= req;
            rd_idx <= '0;
            w      <= '0;
            hit    <= 1'b0;
            p_vld  <= 1'b0;
            state  <= (req.mode == arpc_pkg::MODE_ADD) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          p_vld <= issue;
          p_idx <= rd_idx[IDX_W-1:0];
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (keep_wr) begin
            w <= w + 1'b1;
          end
          if (first_hit) begin
            hit     <= 1'b1;
            hit_idx <= p_idx;
            hit_ent <= q;
          end
          if (scan_end) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp   <= rsp_next;
            cnt   <= cnt_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ARPC_ASSERT(a_cnt_range, cnt <= CNT_W'(arpc_pkg::ENTRIES), "fill count beyond depth")
  `ARPC_ASSERT(a_wr_ptr_behind, (state != S_SCAN) || (w <= rd_idx), "write pointer ahead")
  `ARPC_ASSERT(a_wr_in_range, !(keep_wr && (state == S_SCAN)) || (w < cnt), "write past fill")
  `ARPC_ASSERT(a_no_rw_clash, !(ram_we && issue) || (ram_waddr != ram_raddr), "entry clash")
  `ARPC_ASSERT_NEXT(a_done_delivers, finish, (state == S_IDLE) && rsp_valid, "result lost")

endmodule
`default_nettype wire

### rtl/arpc_ram.sv
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic                                         re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
